// ===== src/tga_pkg.sv =====
// Shared types and constants for the Targa run-length pixel decoder.
`default_nettype none
package tga_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_BYTES  = 2'd0,
    CFG_RLE_ENABLE   = 2'd1,
    CFG_IMAGE_PIXELS = 2'd2
  } cfg_idx_t;

  localparam logic [2:0]  PIXEL_BYTES_RST  = 3'd3;
  localparam logic        RLE_ENABLE_RST   = 1'b1;
  localparam logic [31:0] IMAGE_PIXELS_RST = 32'd1;

  localparam logic [15:0] RED_MASK   = 16'h7c00;
  localparam logic [15:0] GREEN_MASK = 16'h03e0;
  localparam logic [15:0] BLUE_MASK  = 16'h001f;

  typedef struct packed {
    logic [2:0]  pixel_bytes;
    logic        rle_enable;
    logic [31:0] image_pixels;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] repeat_count;
    logic       last_of_image;
  } pix_t;

endpackage
`default_nettype wire

// ===== src/tga_rle_pixel_decoder_unit.sv =====
// Top level of the Targa run-length pixel decoder.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_data_byte[7:0]
//   out_     output     out_valid / out_ready  out_red, out_green, out_blue,
//                                              out_repeat_count, out_last_of_image
//   cfg_     input      cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[31:0]
//
// One byte per cycle while the output is not stalled; each transaction passes an
// input register, then the decode logic writes the output register behind out_valid.
// The pixel count add and compare against image_pixels sets the decode path.
// Synchronous active-low reset; cfg_ready is always high.
// A stalled output holds the input register, and in_ready drops only then.
`default_nettype none
module tga_rle_pixel_decoder_unit
  import tga_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_data_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_blue,
  output logic [7:0]                 out_repeat_count,
  output logic                       out_last_of_image,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       adv;
  logic       fire;
  logic       produce;
  pix_t       pix;
  logic       out_vld_r;
  pix_t       out_r;

  assign cfg_ready = 1'b1;

  tga_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign adv      = !out_vld_r || out_ready;
  assign fire     = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_data_byte;
    end
  end

  tga_decode u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fire      (fire),
    .data_byte (in_byte_r),
    .produce   (produce),
    .pix       (pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= fire && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produce) begin
      out_r <= pix;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_red           = out_r.red;
  assign out_green         = out_r.green;
  assign out_blue          = out_r.blue;
  assign out_repeat_count  = out_r.repeat_count;
  assign out_last_of_image = out_r.last_of_image;

`ifndef NO_ASSERTIONS
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    fire && produce |-> pix.repeat_count != 8'd0)
    else $error("decoded pixel with zero repeat count");

  a_raw_count_one: assert property (@(posedge clk) disable iff (!rst_n)
    fire && produce && !cfg.rle_enable |-> pix.repeat_count == 8'd1)
    else $error("raw mode pixel with repeat count other than one");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(in_byte_r))
    else $error("input register lost a byte while output stalled");
`endif

endmodule
`default_nettype wire

// ===== src/tga_cfg_regs.sv =====
// Configuration register file for the Targa decoder.
`default_nettype none
module tga_cfg_regs
  import tga_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_PIXEL_BYTES:  cfg_nxt.pixel_bytes  = wr_data[2:0];
        CFG_RLE_ENABLE:   cfg_nxt.rle_enable   = wr_data[0];
        CFG_IMAGE_PIXELS: cfg_nxt.image_pixels = wr_data[31:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_bytes  <= PIXEL_BYTES_RST;
      cfg_r.rle_enable   <= RLE_ENABLE_RST;
      cfg_r.image_pixels <= IMAGE_PIXELS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== src/tga_decode.sv =====
// Packet, pixel assembly and pixel count state with single-pass decode logic.
`default_nettype none
module tga_decode
  import tga_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       fire,
  input  wire logic [7:0] data_byte,
  output logic            produce,
  output pix_t            pix
);

  logic        exp_hdr_r, exp_hdr_nxt;
  logic        is_run_r, is_run_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] held_r, held_nxt;
  logic [31:0] done_r, done_nxt;

  logic [1:0]  last_pos;
  logic [15:0] word;
  logic [32:0] sum;
  logic [31:0] sum_sat;
  logic [7:0]  count;
  logic        last;

  always_comb begin
    if (cfg.pixel_bytes == 3'd0) begin
      last_pos = 2'd0;
    end else if (cfg.pixel_bytes > 3'd4) begin
      last_pos = 2'd3;
    end else begin
      last_pos = 2'(cfg.pixel_bytes - 3'd1);
    end
  end

  always_comb begin
    exp_hdr_nxt = exp_hdr_r;
    is_run_nxt  = is_run_r;
    left_nxt    = left_r;
    pos_nxt     = pos_r;
    held_nxt    = held_r;
    done_nxt    = done_r;
    produce     = 1'b0;
    count       = 8'd1;
    pix         = '0;
    word        = {data_byte, held_r[7:0]};
    sum         = '0;
    sum_sat     = '0;
    last        = 1'b0;

    if (cfg.rle_enable && exp_hdr_r) begin
      is_run_nxt  = data_byte[7];
      left_nxt    = {1'b0, data_byte[6:0]} + 8'd1;
      exp_hdr_nxt = 1'b0;
      pos_nxt     = 2'd0;
    end else begin
      case (pos_r)
        2'd0:    held_nxt[7:0]   = data_byte;
        2'd1:    held_nxt[15:8]  = data_byte;
        2'd2:    held_nxt[23:16] = data_byte;
        default: held_nxt        = held_r;
      endcase
      if (pos_r < last_pos) begin
        pos_nxt = pos_r + 2'd1;
      end else begin
        pos_nxt = 2'd0;
        produce = 1'b1;
        word    = {data_byte, held_nxt[7:0]};
        case (last_pos)
          2'd0: begin
            pix.red   = data_byte;
            pix.green = 8'd0;
            pix.blue  = 8'd0;
          end
          2'd1: begin
            pix.red   = {word[14:10] & RED_MASK[14:10], 3'b000};
            pix.green = {word[9:5] & GREEN_MASK[9:5], 3'b000};
            pix.blue  = {word[4:0] & BLUE_MASK[4:0], 3'b000};
          end
          default: begin
            pix.blue  = held_nxt[7:0];
            pix.green = held_nxt[15:8];
            pix.red   = held_nxt[23:16];
          end
        endcase

        if (cfg.rle_enable) begin
          if (is_run_r) begin
            count       = (left_r != 8'd0) ? left_r : 8'd1;
            exp_hdr_nxt = 1'b1;
            left_nxt    = 8'd0;
          end else if (left_r <= 8'd1) begin
            exp_hdr_nxt = 1'b1;
            left_nxt    = 8'd0;
          end else begin
            left_nxt = left_r - 8'd1;
          end
        end

        sum     = {1'b0, done_r} + {25'd0, count};
        sum_sat = sum[32] ? 32'hffff_ffff : sum[31:0];
        last    = (sum_sat >= cfg.image_pixels);
        if (last) begin
          done_nxt    = 32'd0;
          exp_hdr_nxt = 1'b1;
          left_nxt    = 8'd0;
        end else begin
          done_nxt = sum_sat;
        end
        pix.repeat_count  = count;
        pix.last_of_image = last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_hdr_r <= 1'b1;
      is_run_r  <= 1'b0;
      left_r    <= 8'd0;
      pos_r     <= 2'd0;
      held_r    <= 24'd0;
      done_r    <= 32'd0;
    end else if (fire) begin
      exp_hdr_r <= exp_hdr_nxt;
      is_run_r  <= is_run_nxt;
      left_r    <= left_nxt;
      pos_r     <= pos_nxt;
      held_r    <= held_nxt;
      done_r    <= done_nxt;
    end
  end

endmodule
`default_nettype wire
